FILE: design/sensor_average_dew_point_defines.svh
// Assertion macros used by the datapath.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SENSOR_AVERAGE_DEW_POINT_DEFINES_SVH
`define SENSOR_AVERAGE_DEW_POINT_DEFINES_SVH

// Same-cycle implication.
`define SADP_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SADP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sadp_pkg.sv
package sadp_pkg;

    // Field and register widths.
    localparam int CFG_W           = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int T_W             = 15;
    localparam int H_W             = 14;
    localparam int DEW_W           = 16;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 48;

    // Datapath widths.
    localparam int NUM_W  = 48;
    localparam int DEN_W  = 32;
    localparam int Q_W    = NUM_W + 1;
    localparam int L2_W   = 20;
    localparam int LR_W   = 22;
    localparam int G_W    = 24;
    localparam int X_W    = 26;
    localparam int DDEN_W = 34;

    // Magnus constants and fixed-point scale factors.
    localparam int LOG2_10000_Q16 = 870824;
    localparam int LN2_Q16        = 45426;
    localparam int MAG_B          = 1762;
    localparam int MAG_C          = 24312;
    localparam int MAG_BC         = 2431200;
    localparam int MAG_B_Q16      = 1762 * 65536;
    localparam int DEW_MIN        = -27315;
    localparam int DEW_MAX        = 32767;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_GO,
        S_T_RUN,
        S_H_GO,
        S_H_RUN,
        S_LOG_GO,
        S_LOG_RUN,
        S_G_GO,
        S_G_RUN,
        S_X1,
        S_X2,
        S_D_GO,
        S_D_RUN,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_AVG_T,
        OP_AVG_H,
        OP_GAIN,
        OP_DEW
    } div_op_t;

    typedef struct packed {
        logic    accept;
        logic    div_start;
        div_op_t div_op;
        logic    log_start;
        logic    dew_low;
        logic    dew_high;
        logic    load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic block_end;
        logic div_done;
        logic log_done;
        logic h_zero;
        logic den_bad;
        logic out_free;
    } dp_status_t;

endpackage

FILE: design/sadp_div.sv
module sadp_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [sadp_pkg::NUM_W-1:0]    num,
    input  logic        [sadp_pkg::DEN_W-1:0]    den,
    output logic                                 busy,
    output logic                                 done,
    output logic signed [sadp_pkg::Q_W-1:0]      quot
);

    localparam int NW = sadp_pkg::NUM_W;
    localparam int DW = sadp_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic signed [NW-1:0] num_reg;
    logic [DW-1:0]        den_reg;
    logic [NW-1:0]        acc_reg, acc_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic                 prep_reg, prep_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [NW-1:0]        mag;
    logic [DW:0]          rem_sh;
    logic [DW+1:0]        diff;

    // Operand magnitude; round-to-nearest is folded in by adding half the divisor.
    assign mag    = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign rem_sh = {rem_reg, acc_reg[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};

    // One restoring step per cycle.
    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        prep_next = 1'b0;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            prep_next = 1'b1;
        end
        else if (prep_reg)
        begin
            neg_next = num_reg[NW-1];
            acc_next = mag + NW'(den_reg >> 1);
            rem_next = '0;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[DW+1])
            begin
                rem_next = diff[DW-1:0];
                acc_next = {acc_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DW-1:0];
                acc_next = {acc_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            prep_reg <= prep_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
        end
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign busy = prep_reg | run_reg;
    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

endmodule

FILE: design/sadp_log.sv
module sadp_log (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sadp_pkg::H_W-1:0]       h,
    output logic                           done,
    output logic [sadp_pkg::L2_W-1:0]      l2
);

    localparam int HW = sadp_pkg::H_W;

    logic [30:0] x_reg, x_next;
    logic [61:0] sq_reg;
    logic [15:0] frac_reg, frac_next;
    logic [3:0]  e_reg, e_next;
    logic [3:0]  step_reg, step_next;
    logic        run_reg, run_next;
    logic        sq_phase_reg, sq_phase_next;
    logic        done_reg, done_next;
    logic [3:0]  msb;
    logic [31:0] sq_top;

    // Position of the leading one of the input.
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < HW; i++)
        begin
            if (h[i])
            begin
                msb = 4'(i);
            end
        end
    end

    assign sq_top = sq_reg[61:30];

    // Squaring loop: for each result bit, a registered multiply, then a renormalize step.
    always_comb
    begin
        x_next        = x_reg;
        frac_next     = frac_reg;
        e_next        = e_reg;
        step_next     = step_reg;
        run_next      = run_reg;
        sq_phase_next = sq_phase_reg;
        done_next     = 1'b0;
        if (start)
        begin
            e_next        = msb;
            x_next        = 31'(h) << (5'd30 - 5'(msb));
            frac_next     = '0;
            step_next     = '0;
            run_next      = 1'b1;
            sq_phase_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (!sq_phase_reg)
            begin
                sq_phase_next = 1'b1;
            end
            else
            begin
                sq_phase_next = 1'b0;
                if (sq_top[31])
                begin
                    x_next = sq_top[31:1];
                    frac_next[4'd15 - step_reg] = 1'b1;
                end
                else
                begin
                    x_next = sq_top[30:0];
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd15)
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            sq_phase_reg <= 1'b0;
            done_reg     <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            run_reg      <= run_next;
            sq_phase_reg <= sq_phase_next;
            done_reg     <= done_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        frac_reg <= frac_next;
        e_reg    <= e_next;
        sq_reg   <= 62'(x_reg) * 62'(x_reg);
    end

    assign done = done_reg;
    assign l2   = {e_reg, frac_reg};

endmodule

FILE: design/sadp_datapath.sv
`include "sensor_average_dew_point_defines.svh"

module sadp_datapath #(
    parameter int MAX_SAMPLES = sadp_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [sadp_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic                                cfg_valid,
    input  logic [sadp_pkg::CFG_W-1:0]          cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sadp_pkg::M_TDATA_W-1:0]      m_tdata,
    input  sadp_pkg::ctrl_cmd_t                 cmd,
    output sadp_pkg::dp_status_t                st
);

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W   = (CNT_W > sadp_pkg::CFG_W) ? CNT_W : sadp_pkg::CFG_W;
    localparam int SUM_T_W = sadp_pkg::T_W + CNT_W;
    localparam int SUM_H_W = sadp_pkg::H_W + CNT_W;
    localparam int NW      = sadp_pkg::NUM_W;
    localparam int DW      = sadp_pkg::DEN_W;
    localparam int QW      = sadp_pkg::Q_W;

    logic [sadp_pkg::CFG_W-1:0]      spa_reg;
    logic signed [SUM_T_W-1:0]       sum_t_reg, tot_t_reg;
    logic [SUM_H_W-1:0]              sum_h_reg, tot_h_reg;
    logic [CNT_W-1:0]                cnt_reg, tot_n_reg;
    logic signed [sadp_pkg::T_W-1:0] avg_t_reg;
    logic [sadp_pkg::H_W-1:0]        avg_h_reg;
    logic signed [sadp_pkg::G_W-1:0] g_reg;
    logic signed [sadp_pkg::LR_W-1:0] lr_reg;
    logic signed [sadp_pkg::X_W-1:0] x_reg;
    logic signed [26:0]              gnum_reg;
    logic [22:0]                     gden_reg;
    logic signed [NW-1:0]            dnum_reg;
    logic signed [sadp_pkg::DDEN_W-1:0] dden_reg;
    logic signed [sadp_pkg::DEW_W-1:0] dew_reg;
    logic                            out_valid_reg;
    logic [sadp_pkg::M_TDATA_W-1:0]  out_reg;

    logic signed [sadp_pkg::T_W-1:0] t_in;
    logic [sadp_pkg::H_W-1:0]        h_in;
    logic signed [SUM_T_W-1:0]       sum_t_new;
    logic [SUM_H_W-1:0]              sum_h_new;
    logic [CMP_W-1:0]                cfg_n, n_one, n_eff, cnt_inc;
    logic signed [NW-1:0]            div_num;
    logic [DW-1:0]                   div_den;
    logic                            div_busy, div_done;
    logic signed [QW-1:0]            quot;
    logic                            log_done;
    logic [sadp_pkg::L2_W-1:0]       l2;
    logic signed [20:0]              l2_diff;
    logic signed [37:0]              lr_prod;
    logic [37:0]                     lr_mag;
    logic signed [sadp_pkg::LR_W-1:0] lr_new;
    logic signed [sadp_pkg::DEW_W-1:0] dew_calc;

    assign t_in = $signed(s_tdata[sadp_pkg::T_W-1:0]);
    assign h_in = s_tdata[sadp_pkg::T_W +: sadp_pkg::H_W];

    // Effective block size: zero means one, capped at the accumulator depth.
    assign cfg_n   = CMP_W'(spa_reg);
    assign n_one   = (cfg_n == '0) ? CMP_W'(1) : cfg_n;
    assign n_eff   = (n_one > CMP_W'(MAX_SAMPLES)) ? CMP_W'(MAX_SAMPLES) : n_one;
    assign cnt_inc = CMP_W'(cnt_reg) + CMP_W'(1);

    assign sum_t_new = sum_t_reg + SUM_T_W'(t_in);
    assign sum_h_new = sum_h_reg + SUM_H_W'(h_in);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spa_reg <= sadp_pkg::CFG_RESET;
        end
        else if (cfg_valid)
        begin
            spa_reg <= cfg_data;
        end
    end

    // Accumulators; a completed block is handed to the divide sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_t_reg <= '0;
            sum_h_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.accept && s_tuser)
        begin
            if (st.block_end)
            begin
                sum_t_reg <= '0;
                sum_h_reg <= '0;
                cnt_reg   <= '0;
            end
            else
            begin
                sum_t_reg <= sum_t_new;
                sum_h_reg <= sum_h_new;
                cnt_reg   <= cnt_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && st.block_end)
        begin
            tot_t_reg <= sum_t_new;
            tot_h_reg <= sum_h_new;
            tot_n_reg <= cnt_inc[CNT_W-1:0];
        end
    end

    // Divider operand select.
    always_comb
    begin
        case (cmd.div_op)
            sadp_pkg::OP_AVG_T:
            begin
                div_num = NW'(tot_t_reg);
                div_den = DW'(tot_n_reg);
            end
            sadp_pkg::OP_AVG_H:
            begin
                div_num = $signed(NW'(tot_h_reg));
                div_den = DW'(tot_n_reg);
            end
            sadp_pkg::OP_GAIN:
            begin
                div_num = NW'(gnum_reg) <<< 16;
                div_den = DW'(gden_reg);
            end
            sadp_pkg::OP_DEW:
            begin
                div_num = dnum_reg;
                div_den = dden_reg[DW-1:0];
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    sadp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    sadp_log u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.log_start),
        .h     (avg_h_reg),
        .done  (log_done),
        .l2    (l2)
    );

    // Natural log in Q16 from the base-two log, rounded half away from zero.
    assign l2_diff = $signed({1'b0, l2}) - 21'(sadp_pkg::LOG2_10000_Q16);
    assign lr_prod = 38'(l2_diff) * 38'(sadp_pkg::LN2_Q16);
    assign lr_mag  = lr_prod[37] ? 38'(-lr_prod) : 38'(lr_prod);
    always_comb
    begin
        if (lr_prod[37])
        begin
            lr_new = -$signed(sadp_pkg::LR_W'((lr_mag + 38'd32768) >> 16));
        end
        else
        begin
            lr_new = $signed(sadp_pkg::LR_W'((lr_mag + 38'd32768) >> 16));
        end
    end

    // Dew point saturation.
    always_comb
    begin
        if (quot < $signed(QW'(sadp_pkg::DEW_MIN)))
        begin
            dew_calc = sadp_pkg::DEW_W'(sadp_pkg::DEW_MIN);
        end
        else if (quot > $signed(QW'(sadp_pkg::DEW_MAX)))
        begin
            dew_calc = sadp_pkg::DEW_W'(sadp_pkg::DEW_MAX);
        end
        else
        begin
            dew_calc = quot[sadp_pkg::DEW_W-1:0];
        end
    end

    // Magnus terms, each register fed by at most one multiply.
    always_ff @(posedge clk)
    begin
        lr_reg   <= lr_new;
        gnum_reg <= 27'(avg_t_reg) * 27'(sadp_pkg::MAG_B);
        gden_reg <= 23'(27'(sadp_pkg::MAG_C) + 27'(avg_t_reg)) * 23'd100;
        x_reg    <= sadp_pkg::X_W'(lr_reg) + sadp_pkg::X_W'(g_reg);
        dnum_reg <= NW'(x_reg) * NW'(sadp_pkg::MAG_BC);
        dden_reg <= sadp_pkg::DDEN_W'(sadp_pkg::MAG_B_Q16)
                    - sadp_pkg::DDEN_W'(x_reg) * sadp_pkg::DDEN_W'(100);
    end

    // Result capture from the shared divider, and the forced dew point limits.
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (cmd.div_op)
                sadp_pkg::OP_AVG_T: avg_t_reg <= quot[sadp_pkg::T_W-1:0];
                sadp_pkg::OP_AVG_H: avg_h_reg <= quot[sadp_pkg::H_W-1:0];
                sadp_pkg::OP_GAIN:  g_reg     <= quot[sadp_pkg::G_W-1:0];
                sadp_pkg::OP_DEW:   dew_reg   <= dew_calc;
                default:            dew_reg   <= dew_reg;
            endcase
        end
        else if (cmd.dew_low)
        begin
            dew_reg <= sadp_pkg::DEW_W'(sadp_pkg::DEW_MIN);
        end
        else if (cmd.dew_high)
        begin
            dew_reg <= sadp_pkg::DEW_W'(sadp_pkg::DEW_MAX);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= {3'b000, dew_reg, avg_h_reg, avg_t_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign st.block_end = s_tuser && (cnt_inc >= n_eff);
    assign st.div_done  = div_done;
    assign st.log_done  = log_done;
    assign st.h_zero    = (avg_h_reg == '0);
    assign st.den_bad   = (dden_reg <= 0);
    assign st.out_free  = !out_valid_reg || m_tready;

    `SADP_CHECK_NEXT(a_count_step, cmd.accept && s_tuser && !st.block_end,
        cnt_reg == $past(cnt_reg) + 1'b1, "sample count did not advance")
    `SADP_CHECK_NEXT(a_out_loaded, cmd.load_out, m_tvalid, "result word not presented")
    `SADP_CHECK_NOW(a_div_idle, cmd.div_start, !div_busy, "divider started while busy")

endmodule

FILE: design/sadp_ctrl.sv
module sadp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  sadp_pkg::dp_status_t  st,
    output sadp_pkg::ctrl_cmd_t   cmd
);

    sadp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sadp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sadp_pkg::S_IDLE:
                if (s_tvalid && st.block_end) state_next = sadp_pkg::S_T_GO;
            sadp_pkg::S_T_GO:   state_next = sadp_pkg::S_T_RUN;
            sadp_pkg::S_T_RUN:
                if (st.div_done) state_next = sadp_pkg::S_H_GO;
            sadp_pkg::S_H_GO:   state_next = sadp_pkg::S_H_RUN;
            sadp_pkg::S_H_RUN:
                if (st.div_done) state_next = sadp_pkg::S_LOG_GO;
            sadp_pkg::S_LOG_GO:
                state_next = st.h_zero ? sadp_pkg::S_OUT : sadp_pkg::S_LOG_RUN;
            sadp_pkg::S_LOG_RUN:
                if (st.log_done) state_next = sadp_pkg::S_G_GO;
            sadp_pkg::S_G_GO:   state_next = sadp_pkg::S_G_RUN;
            sadp_pkg::S_G_RUN:
                if (st.div_done) state_next = sadp_pkg::S_X1;
            sadp_pkg::S_X1:     state_next = sadp_pkg::S_X2;
            sadp_pkg::S_X2:     state_next = sadp_pkg::S_D_GO;
            sadp_pkg::S_D_GO:
                state_next = st.den_bad ? sadp_pkg::S_OUT : sadp_pkg::S_D_RUN;
            sadp_pkg::S_D_RUN:
                if (st.div_done) state_next = sadp_pkg::S_OUT;
            sadp_pkg::S_OUT:
                if (st.out_free) state_next = sadp_pkg::S_IDLE;
            default:            state_next = sadp_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.div_op    = sadp_pkg::OP_AVG_T;
        s_tready      = 1'b0;
        case (state_reg)
            sadp_pkg::S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            sadp_pkg::S_T_GO:
            begin
                cmd.div_start = 1'b1;
            end
            sadp_pkg::S_H_GO:
            begin
                cmd.div_op    = sadp_pkg::OP_AVG_H;
                cmd.div_start = 1'b1;
            end
            sadp_pkg::S_H_RUN:
            begin
                cmd.div_op = sadp_pkg::OP_AVG_H;
            end
            sadp_pkg::S_LOG_GO:
            begin
                cmd.div_op    = sadp_pkg::OP_AVG_H;
                cmd.log_start = !st.h_zero;
                cmd.dew_low   = st.h_zero;
            end
            sadp_pkg::S_G_GO:
            begin
                cmd.div_op    = sadp_pkg::OP_GAIN;
                cmd.div_start = 1'b1;
            end
            sadp_pkg::S_G_RUN, sadp_pkg::S_X1, sadp_pkg::S_X2:
            begin
                cmd.div_op = sadp_pkg::OP_GAIN;
            end
            sadp_pkg::S_D_GO:
            begin
                cmd.div_op    = sadp_pkg::OP_DEW;
                cmd.div_start = !st.den_bad;
                cmd.dew_high  = st.den_bad;
            end
            sadp_pkg::S_D_RUN:
            begin
                cmd.div_op = sadp_pkg::OP_DEW;
            end
            sadp_pkg::S_OUT:
            begin
                cmd.div_op   = sadp_pkg::OP_DEW;
                cmd.load_out = st.out_free;
            end
            default:
            begin
                cmd.div_op = sadp_pkg::OP_AVG_T;
            end
        endcase
    end

endmodule

FILE: design/sensor_average_dew_point.sv
// Block-average dew point unit. Each input word carries one temperature and
// humidity sample; words with the valid flag low are dropped. Valid samples
// are summed until the block size written on the configuration channel is
// reached, then one output word gives the rounded mean temperature, mean
// humidity and Magnus dew point, all in hundredths. A word that does not
// complete a block is accepted without a stall. A word that completes a block
// starts a sequence of four divisions on one shared bit-serial divider, a
// squaring logarithm, term setup and output load, during which no input word
// is taken. Zero mean humidity skips the logarithm and the last two divisions,
// and a non-positive Magnus denominator skips the last one. If the previous
// result has not been taken, the sequence also waits in its last state until
// the output register is free; a finished result waits in the output register
// while the next input word is accepted.
module sensor_average_dew_point #(
    parameter int MAX_SAMPLES = sadp_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // temperature_sample[14:0], humidity_sample[28:15], zero fill
    input  logic [sadp_pkg::S_TDATA_W-1:0]    s_tdata,
    // sample_valid[0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // average_temperature[14:0], average_humidity[28:15], dew_point[44:29], zero fill
    output logic [sadp_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sadp_pkg::CFG_W-1:0]        cfg_data
);

    sadp_pkg::ctrl_cmd_t  cmd;
    sadp_pkg::dp_status_t st;

    assign cfg_ready = 1'b1;

    sadp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sadp_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser[0]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

FILE: verif/tb_sensor_average_dew_point.sv
`timescale 1ns / 1ps

module tb_sensor_average_dew_point;

    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 700;

    typedef struct packed {
        logic [sadp_pkg::DEW_W-1:0] dew;
        logic [sadp_pkg::H_W-1:0]   hum;
        logic [sadp_pkg::T_W-1:0]   temp;
    } dew_word_t;

    typedef struct {
        int t;
        int h;
        bit v;
        bit typed;
        int dew;
    } sample_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [sadp_pkg::S_TDATA_W-1:0] s_tdata;
    logic [0:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [sadp_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [sadp_pkg::CFG_W-1:0]     cfg_data;

    sensor_average_dew_point dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Predictor state: running sums, sample count and block size.
    longint        temp_sum;
    longint        hum_sum;
    int            sample_count;
    logic [sadp_pkg::CFG_W-1:0] block_size;
    dew_word_t     pending_words[$];
    int            error_count;
    bit            idle_enable;
    bit            hold_request;

    // Rounded division, ties away from zero.
    function automatic longint round_div(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    // floor(log2(h) * 2^16) by repeated squaring of a Q30 mantissa.
    function automatic longint log2_fixed(longint h);
        longint e;
        longint x;
        longint frac;
        e = 0;
        frac = 0;
        while (e < 31 && (h >> (e + 1)) != 0)
            e++;
        x = (h << 30) >> e;
        for (int i = 1; i <= 16; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (longint'(1) << 31))
            begin
                x = x >> 1;
                frac = frac | (longint'(1) << (16 - i));
            end
        end
        return (e << 16) + frac;
    endfunction

    // Magnus dew point in hundredths from the rounded means.
    function automatic longint magnus_dew(longint t, longint h);
        longint lr;
        longint g;
        longint x;
        longint den;
        longint dew;
        if (h <= 0)
            return sadp_pkg::DEW_MIN;
        lr = round_div((log2_fixed(h) - sadp_pkg::LOG2_10000_Q16) * sadp_pkg::LN2_Q16, 65536);
        g = round_div(1762 * t * 65536, 100 * (24312 + t));
        x = lr + g;
        den = longint'(1762) * 65536 - 100 * x;
        if (den <= 0)
            return sadp_pkg::DEW_MAX;
        dew = round_div(2431200 * x, den);
        if (dew < sadp_pkg::DEW_MIN)
            dew = sadp_pkg::DEW_MIN;
        if (dew > sadp_pkg::DEW_MAX)
            dew = sadp_pkg::DEW_MAX;
        return dew;
    endfunction

    // Accumulate one accepted sample; returns 1 when a block completes.
    function automatic bit accumulate_sample(logic [sadp_pkg::T_W-1:0] t_raw,
                                             logic [sadp_pkg::H_W-1:0] h_raw,
                                             logic v, output dew_word_t word);
        longint t;
        longint avg_t;
        longint avg_h;
        int     n;
        t = longint'($signed(t_raw));
        word = '0;
        if (!v)
            return 0;
        n = block_size;
        if (n < 1)
            n = 1;
        if (n > sadp_pkg::MAX_SAMPLES_DEF)
            n = sadp_pkg::MAX_SAMPLES_DEF;
        temp_sum += t;
        hum_sum += longint'(h_raw);
        sample_count++;
        if (sample_count < n)
            return 0;
        avg_t = round_div(temp_sum, sample_count);
        avg_h = round_div(hum_sum, sample_count);
        word.temp = avg_t[sadp_pkg::T_W-1:0];
        word.hum  = avg_h[sadp_pkg::H_W-1:0];
        word.dew  = sadp_pkg::DEW_W'(magnus_dew(avg_t, avg_h));
        temp_sum = 0;
        hum_sum = 0;
        sample_count = 0;
        return 1;
    endfunction

    // Offer one word until accepted, with random gaps before it.
    task automatic send_sample(logic [sadp_pkg::T_W-1:0] t, logic [sadp_pkg::H_W-1:0] h,
                               logic v, bit typed = 0, int typed_dew = 0);
        dew_word_t word;
        while (idle_enable && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, h, t};
        s_tuser  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        if (accumulate_sample(t, h, v, word))
        begin
            if (typed)
                word.dew = sadp_pkg::DEW_W'(typed_dew);
            pending_words.push_back(word);
        end
    endtask

    // Drain every expected word, let the block settle, then write the block size.
    task automatic write_block_size(logic [sadp_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        block_size = value;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random sample: mostly in the sensor range, sometimes anywhere in the field.
    task automatic send_random_sample();
        logic [sadp_pkg::T_W-1:0] t;
        logic [sadp_pkg::H_W-1:0] h;
        logic                     v;
        if ($urandom_range(9) == 0)
        begin
            t = sadp_pkg::T_W'($urandom);
            h = sadp_pkg::H_W'($urandom);
        end
        else
        begin
            t = sadp_pkg::T_W'($urandom_range(12500) - 4000);
            h = ($urandom_range(19) == 0) ? '0 : sadp_pkg::H_W'($urandom_range(10000));
        end
        v = ($urandom_range(9) != 0);
        send_sample(t, h, v);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random back-pressure, long hold on request, and word checking.
    initial
    begin
        dew_word_t got;
        dew_word_t want;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[sadp_pkg::T_W+sadp_pkg::H_W+sadp_pkg::DEW_W-1:0];
                if (pending_words.size() == 0)
                begin
                    $error("output word with no expectation: %h", got);
                    error_count++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (got.temp !== want.temp)
                    begin
                        $error("average_temperature: expected %0d, got %0d",
                               $signed(want.temp), $signed(got.temp));
                        error_count++;
                    end
                    if (got.hum !== want.hum)
                    begin
                        $error("average_humidity: expected %0d, got %0d", want.hum, got.hum);
                        error_count++;
                    end
                    if (got.dew !== want.dew)
                    begin
                        $error("dew_point: expected %0d, got %0d",
                               $signed(want.dew), $signed(got.dew));
                        error_count++;
                    end
                end
            end
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 0;
            end
            m_tready <= !(idle_enable && $urandom_range(99) < 26);
        end
    end

    // Stimulus.
    initial
    begin
        sample_row_t rows[$];
        logic [sadp_pkg::CFG_W-1:0] phase_sizes[$];
        int total_items;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        temp_sum = 0;
        hum_sum = 0;
        sample_count = 0;
        block_size = sadp_pkg::CFG_RESET;
        error_count = 0;
        idle_enable = 1;
        hold_request = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With a block of one, every valid word is its own average.
        rows = '{
            '{0, 5000, 1, 0, 0},
            '{-4000, 0, 1, 1, sadp_pkg::DEW_MIN},
            '{8500, 0, 1, 1, sadp_pkg::DEW_MIN},
            '{0, 0, 1, 1, sadp_pkg::DEW_MIN},
            '{-16384, 0, 1, 1, sadp_pkg::DEW_MIN},
            '{16383, 0, 1, 1, sadp_pkg::DEW_MIN},
            '{-4000, 10000, 1, 0, 0},
            '{8500, 10000, 1, 0, 0},
            '{8500, 1, 1, 0, 0},
            '{-4000, 1, 1, 0, 0},
            '{2500, 10000, 1, 0, 0},
            '{2000, 4500, 1, 0, 0},
            '{16383, 16383, 1, 0, 0},
            '{-16384, 16383, 1, 0, 0},
            '{-16384, 1, 1, 0, 0},
            '{16383, 1, 1, 0, 0},
            '{1234, 6789, 0, 0, 0},
            '{-1, 16383, 0, 0, 0},
            '{-21845, 10922, 1, 0, 0},
            '{10922, 5461, 1, 0, 0}
        };
        write_block_size(7'd1);
        foreach (rows[i])
            send_sample(sadp_pkg::T_W'(rows[i].t), sadp_pkg::H_W'(rows[i].h), rows[i].v,
                        rows[i].typed, rows[i].dew);

        // Random phases over a range of block sizes, extremes and clamped values included.
        phase_sizes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd16, 7'd2, 7'd3, 7'd5, 7'd8, 7'd33};
        total_items = 0;
        foreach (phase_sizes[p])
        begin
            write_block_size(phase_sizes[p]);
            idle_enable = (p != 4);
            for (int k = 0; k < 177; k++)
            begin
                if (p == 0 && k == 20)
                    hold_request = 1;
                if (p == 5 && k == 90)
                begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                send_random_sample();
                total_items++;
            end
        end
        write_block_size(sadp_pkg::CFG_W'($urandom_range(1, 64)));
        idle_enable = 1;
        repeat (60) send_random_sample();
        s_tvalid <= 1'b0;

        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/sadp_pkg.sv
design/sadp_div.sv
design/sadp_log.sv
design/sadp_datapath.sv
design/sadp_ctrl.sv
design/sensor_average_dew_point.sv
verif/tb_sensor_average_dew_point.sv
